FILE: hdl/phwa_pkg.sv
// ----------------------------------------------------------------------------
// phwa_pkg
// Shared types and constants for the position histogram window alert block.
// ----------------------------------------------------------------------------
package phwa_pkg;

  // Histogram geometry.
  localparam int unsigned NUM_POSITIONS = 4096;
  localparam int unsigned COUNT_WIDTH   = 16;
  localparam int unsigned ADDR_W        = $clog2(NUM_POSITIONS);

  // Field widths fixed by the item format.
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned SPAN_W  = 8;
  localparam int unsigned TOTAL_W = 16;

  // Running window address, wide enough to run past the last position.
  localparam int unsigned IDX_W = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 1;

  // Window sum, wide enough for a full window of saturated bins.
  localparam int unsigned SUM_RAW_W = COUNT_WIDTH + SPAN_W + 1;
  localparam int unsigned SUM_W     = (SUM_RAW_W > TOTAL_W + 1) ? SUM_RAW_W : TOTAL_W + 1;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SPAN     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THRESHOLD = 1'd1;
  localparam logic [SPAN_W-1:0]    SPAN_RESET          = 8'd100;
  localparam logic [TOTAL_W-1:0]   THRESHOLD_RESET     = 16'd100;

  // Function codes carried by an input item.
  localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    op_e              op;
    logic             in_range;
    logic [POS_W-1:0] pos;
  } cmd_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end status seen by the front.
  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

FILE: hdl/phwa_in_if.sv
// ----------------------------------------------------------------------------
// phwa_in_if
// Input channel: one function code and one cable position per item.
// ----------------------------------------------------------------------------
interface phwa_in_if;
  import phwa_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;

  modport source (output valid, output func, output position, input ready);
  modport sink   (input valid, input func, input position, output ready);
endinterface

FILE: hdl/phwa_out_if.sv
// ----------------------------------------------------------------------------
// phwa_out_if
// Output channel: window total and alert flag per item.
// ----------------------------------------------------------------------------
interface phwa_out_if;
  import phwa_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] window_total;
  logic               alert;

  modport source (output valid, output window_total, output alert, input ready);
  modport sink   (input valid, input window_total, input alert, output ready);
endinterface

FILE: hdl/phwa_front.sv
// ----------------------------------------------------------------------------
// phwa_front
// Accepts input items, decodes the function and range-checks the position,
// and pushes a command into the queue.
// ----------------------------------------------------------------------------
module phwa_front (
  phwa_in_if.sink                 in_if,
  input  phwa_pkg::q_stat_t       q_stat_i,
  input  phwa_pkg::back_stat_t    back_stat_i,
  output logic                    push_o,
  output phwa_pkg::cmd_t          cmd_o
);
  import phwa_pkg::*;

  // Hold off while the queue is full or the histogram is being initialized.
  assign in_if.ready = !q_stat_i.full && !back_stat_i.init_busy;
  assign push_o      = in_if.valid && in_if.ready;

  // Decode the function code; the unused code becomes a no-op.
  always_comb begin
    cmd_o.pos      = in_if.position;
    cmd_o.in_range = ({1'b0, in_if.position} < (POS_W + 1)'(NUM_POSITIONS))
                     || (POS_W < ADDR_W);
    case (in_if.func)
      FUNC_RECORD: cmd_o.op = OP_RECORD;
      FUNC_QUERY:  cmd_o.op = OP_QUERY;
      FUNC_CLEAR:  cmd_o.op = OP_CLEAR;
      default:     cmd_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: hdl/phwa_fifo.sv
// ----------------------------------------------------------------------------
// phwa_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module phwa_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  phwa_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output phwa_pkg::cmd_t     cmd_o,
  output phwa_pkg::q_stat_t  stat_o
);
  import phwa_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign cmd_o        = entry_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hdl/phwa_back.sv
// ----------------------------------------------------------------------------
// phwa_back
// Executes commands against the histogram memory: record, window query and
// clear, and holds each result in an output register.
// ----------------------------------------------------------------------------
module phwa_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  phwa_pkg::cmd_t                 cmd_i,
  input  phwa_pkg::q_stat_t              q_stat_i,
  output logic                           pop_o,
  input  logic [phwa_pkg::SPAN_W-1:0]    window_span_i,
  input  logic [phwa_pkg::TOTAL_W-1:0]   alert_threshold_i,
  output phwa_pkg::back_stat_t           stat_o,
  phwa_out_if.source                     out_if
);
  import phwa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_REC_RD,
    S_REC_WR,
    S_QRY,
    S_QRY_DRAIN,
    S_DONE
  } state_e;

  localparam logic [COUNT_WIDTH-1:0] BIN_MAX = '1;

  // Histogram memory, single port, registered read.
  logic [COUNT_WIDTH-1:0] mem [NUM_POSITIONS];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_addr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  state_e             state_q, state_d;
  logic               init_q, init_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [SPAN_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               rd_vld_q, rd_vld_d;
  logic               is_qry_q, is_qry_d;
  logic               out_vld_q, out_vld_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;
  logic               out_alert_q, out_alert_d;

  logic               addr_ok;
  logic [SUM_W-1:0]   sum_acc;

  assign stat_o.init_busy = init_q;
  assign out_if.valid        = out_vld_q;
  assign out_if.window_total = out_total_q;
  assign out_if.alert        = out_alert_q;

  assign addr_ok = (addr_q < IDX_W'(NUM_POSITIONS));
  assign sum_acc = rd_vld_q ? (sum_q + SUM_W'(rdata_q)) : sum_q;

  // Sequencer for one command at a time.
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    is_qry_d    = is_qry_q;
    rd_vld_d    = 1'b0;
    out_vld_d   = out_vld_q;
    out_total_d = out_total_q;
    out_alert_d = out_alert_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = addr_q[ADDR_W-1:0];
    mem_wdata   = '0;

    // Result register drains independently of the sequencer.
    if (out_vld_q && out_if.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o    = 1'b1;
          addr_d   = IDX_W'(cmd_i.pos);
          cnt_d    = '0;
          sum_d    = '0;
          is_qry_d = 1'b0;
          case (cmd_i.op)
            OP_RECORD: state_d = cmd_i.in_range ? S_REC_RD : S_DONE;
            OP_QUERY: begin
              is_qry_d = 1'b1;
              state_d  = S_QRY;
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // Zero one bin per cycle.
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == ADDR_W'(NUM_POSITIONS - 1)) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_DONE;
        end
      end

      S_REC_RD: begin
        mem_re  = 1'b1;
        state_d = S_REC_WR;
      end

      // Saturating increment of the bin just read.
      S_REC_WR: begin
        if (rdata_q != BIN_MAX) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q + 1'b1;
        end
        state_d = S_DONE;
      end

      // Issue one read per cycle and add the bin read in the previous cycle.
      S_QRY: begin
        mem_re   = addr_ok;
        rd_vld_d = addr_ok;
        sum_d    = sum_acc;
        addr_d   = addr_q + 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if ((cnt_q == window_span_i) || !addr_ok) begin
          state_d = S_QRY_DRAIN;
        end
      end

      S_QRY_DRAIN: begin
        sum_d   = sum_acc;
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_vld_q || out_if.ready) begin
          out_vld_d   = 1'b1;
          out_total_d = (sum_q > SUM_W'({TOTAL_W{1'b1}})) ? '1 : sum_q[TOTAL_W-1:0];
          out_alert_d = is_qry_q && (sum_q >= SUM_W'(alert_threshold_i));
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      init_q    <= 1'b1;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      is_qry_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      clr_q     <= clr_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      is_qry_q  <= is_qry_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    cnt_q       <= cnt_d;
    sum_q       <= sum_d;
    out_total_q <= out_total_d;
    out_alert_q <= out_alert_d;
  end

  // Histogram memory port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

endmodule

FILE: hdl/position_histogram_window_alert.sv
// ----------------------------------------------------------------------------
// position_histogram_window_alert
// Histogram of deformation counts per cable position with window queries
// and a threshold alert.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake      Payload
//   in_if    sink       valid/ready    func, position
//   out_if   source     valid/ready    window_total, alert
//   cfg      write      cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// A query runs in the back end through dispatch, one bin read per cycle from
// the single-port histogram memory, drain and result load; a window that runs
// past the last position ends early. A record reads and writes back its bin,
// and a clear zeroes all NUM_POSITIONS bins.
// After reset the memory is zeroed while in_if.ready stays low. A two-entry
// command queue keeps taking items while the back end works or out_if is
// stalled, until it is full.
// ----------------------------------------------------------------------------
module position_histogram_window_alert (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  phwa_in_if.sink                           in_if,
  phwa_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [phwa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [phwa_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import phwa_pkg::*;

  logic [SPAN_W-1:0]  span_q;
  logic [TOTAL_W-1:0] alert_thr_q;

  logic       push, pop;
  cmd_t       push_cmd, head_cmd;
  q_stat_t    q_stat;
  back_stat_t back_stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q      <= SPAN_RESET;
      alert_thr_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SPAN:     span_q      <= cfg_wdata_i[SPAN_W-1:0];
        CFG_ALERT_THRESHOLD: alert_thr_q <= cfg_wdata_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  phwa_front u_front (
    .in_if       (in_if),
    .q_stat_i    (q_stat),
    .back_stat_i (back_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  phwa_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  phwa_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (head_cmd),
    .q_stat_i          (q_stat),
    .pop_o             (pop),
    .window_span_i     (span_q),
    .alert_threshold_i (alert_thr_q),
    .stat_o            (back_stat),
    .out_if            (out_if)
  );

`ifndef SYNTHESIS
  // No item is taken while the histogram is being initialized.
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.init_busy |-> !in_if.ready)
    else $error("item accepted during histogram initialization");

  // The queue never receives an item when full, and is never popped empty.
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full && !pop) && !(pop && q_stat.empty))
    else $error("command queue overflow or underflow");

  // An alert always comes with a total at or above the threshold.
  a_alert_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.alert) |-> (out_if.window_total >= alert_thr_q))
    else $error("alert raised below threshold");
`endif

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the position histogram window alert block. It keeps
// its own histogram and configuration registers, and from them predicts the
// window total and the alert flag of every item the block takes. Directed
// items cover the reset settings, the register extremes, windows that run
// past the last position, unused function codes and counts piled on one bin.
// Random phases then run with and without idle cycles on either channel, and
// a long output hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import phwa_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS    = 150;

  // Function code that the block takes but does nothing with.
  localparam logic [FUNC_W-1:0]      FUNC_UNUSED = 2'd3;
  localparam logic [COUNT_WIDTH-1:0] BIN_MAX     = '1;
  localparam logic [31:0]            TOTAL_MAX   = 32'd65535;

  typedef struct packed {
    logic [TOTAL_W-1:0] window_total;
    logic               alert;
  } window_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  phwa_in_if  in_ch ();
  phwa_out_if out_ch ();

  position_histogram_window_alert dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow copy of the histogram and of the two registers.
  logic [COUNT_WIDTH-1:0] hist_bins [NUM_POSITIONS];
  logic [SPAN_W-1:0]      span_cfg;
  logic [TOTAL_W-1:0]     threshold_cfg;

  window_result_t expected_window_results [$];
  int error_count;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_requests;

  function automatic void clear_histogram();
    foreach (hist_bins[i]) hist_bins[i] = '0;
  endfunction

  // Applies one item to the shadow histogram and returns its window result.
  function automatic window_result_t predict_window_result(input logic [FUNC_W-1:0] func,
                                                           input logic [POS_W-1:0]  pos);
    window_result_t res;
    logic [31:0]    sum;
    int unsigned    idx;
    res = '0;
    sum = '0;
    case (func)
      FUNC_RECORD: begin
        if (int'(pos) < NUM_POSITIONS && hist_bins[pos] != BIN_MAX) begin
          hist_bins[pos] = hist_bins[pos] + 1'b1;
        end
      end
      FUNC_QUERY: begin
        // Bins past the last position add nothing.
        for (int k = 0; k <= int'(span_cfg); k++) begin
          idx = int'(pos) + k;
          if (idx < NUM_POSITIONS) begin
            sum += hist_bins[idx];
          end
        end
        res.alert        = (sum >= threshold_cfg);
        res.window_total = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
      end
      FUNC_CLEAR: clear_histogram();
      default: ;
    endcase
    return res;
  endfunction

  // Offers one item, waits for it to be taken and records its expected result.
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.position <= pos;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    expected_window_results.push_back(predict_window_result(func, pos));
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_window_results.size() != 0) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_WINDOW_SPAN:     span_cfg = data[SPAN_W-1:0];
      CFG_ALERT_THRESHOLD: threshold_cfg = data[TOTAL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Items under the reset settings: span 100, threshold 100.
  task automatic test_reset_defaults();
    send_item(FUNC_QUERY, 12'd0);
    send_item(FUNC_UNUSED, 12'd4095);
    send_item(FUNC_RECORD, 12'd0);
    send_item(FUNC_RECORD, 12'd4095);
    send_item(FUNC_RECORD, 12'd100);
    send_item(FUNC_RECORD, 12'd101);
    send_item(FUNC_QUERY, 12'd0);
    send_item(FUNC_QUERY, 12'd4095);
    send_item(FUNC_QUERY, 12'd1);
    send_item(FUNC_UNUSED, 12'd0);
    send_item(FUNC_CLEAR, 12'hA5A);
    send_item(FUNC_QUERY, 12'd0);
    wait_drained();
  endtask

  // Register extremes, the alert boundary and a window past the end.
  task automatic test_config_extremes();
    write_config(CFG_ALERT_THRESHOLD, 16'd0);
    write_config(CFG_WINDOW_SPAN, 16'd0);
    send_item(FUNC_QUERY, 12'd2000);
    repeat (3) send_item(FUNC_RECORD, 12'd3000);
    send_item(FUNC_QUERY, 12'd3000);
    wait_drained();
    write_config(CFG_ALERT_THRESHOLD, 16'd3);
    send_item(FUNC_QUERY, 12'd3000);
    wait_drained();
    write_config(CFG_ALERT_THRESHOLD, 16'd4);
    send_item(FUNC_QUERY, 12'd3000);
    wait_drained();
    write_config(CFG_WINDOW_SPAN, 16'd255);
    write_config(CFG_ALERT_THRESHOLD, 16'd65535);
    send_item(FUNC_QUERY, 12'd2900);
    send_item(FUNC_RECORD, 12'd4095);
    send_item(FUNC_QUERY, 12'd3900);
    wait_drained();
  endtask

  // Random items clustered around a moving spot so that windows collect counts.
  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input int span, input int threshold);
    logic [POS_W-1:0]  hot_base;
    logic [POS_W-1:0]  pos;
    logic [FUNC_W-1:0] func;
    int                pick;
    write_config(CFG_WINDOW_SPAN, CFG_DATA_W'(span));
    write_config(CFG_ALERT_THRESHOLD, CFG_DATA_W'(threshold));
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    hot_base = POS_W'($urandom_range(NUM_POSITIONS - 1));
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(99) < 4) hot_base = POS_W'($urandom_range(NUM_POSITIONS - 1));
      pick = $urandom_range(99);
      if ($urandom_range(99) < 15) begin
        pos = POS_W'($urandom);
      end else if (pick < 60) begin
        pos = hot_base + POS_W'($urandom_range(span));
      end else begin
        pos = hot_base + POS_W'($urandom_range(span)) - POS_W'($urandom_range(span));
      end
      if (pick < 2) begin
        func = FUNC_CLEAR;
      end else if (pick < 5) begin
        func = FUNC_UNUSED;
      end else if (pick < 60) begin
        func = FUNC_RECORD;
      end else begin
        func = FUNC_QUERY;
      end
      send_item(func, pos);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0, 16, $urandom_range(3, 20));
    run_random_phase(54, 0, 255, $urandom_range(10, 60));
    run_random_phase(0, 54, 0, $urandom_range(1, 8));
    run_random_phase(8, 8, $urandom_range(1, 254), $urandom_range(0, 40));
  endtask

  // The output holds off while items keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    write_config(CFG_WINDOW_SPAN, 16'd8);
    write_config(CFG_ALERT_THRESHOLD, 16'd2);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_requests++;
    for (int i = 0; i < 12; i++) begin
      send_item((i % 3 == 2) ? FUNC_QUERY : FUNC_RECORD, POS_W'(500 + i));
    end
    // The sender pauses here until the block has returned everything.
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      send_item((i % 2 == 1) ? FUNC_QUERY : FUNC_RECORD, POS_W'(504 + i));
    end
    wait_drained();
  endtask

  // Piles counts onto one bin and checks the alert right at its boundary.
  task automatic test_bin_accumulation();
    write_config(CFG_WINDOW_SPAN, 16'd1);
    write_config(CFG_ALERT_THRESHOLD, 16'd41);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (40) send_item(FUNC_RECORD, 12'd4000);
    send_item(FUNC_RECORD, 12'd4001);
    send_item(FUNC_QUERY, 12'd4000);
    wait_drained();
    write_config(CFG_WINDOW_SPAN, 16'd0);
    send_item(FUNC_QUERY, 12'd4000);
    send_item(FUNC_QUERY, 12'd4001);
    send_item(FUNC_CLEAR, 12'd0);
    send_item(FUNC_QUERY, 12'd4000);
    wait_drained();
  endtask

  // Output side: ready pattern, with a counted hold-off when one is requested.
  initial begin : result_receiver
    int stall_left;
    int served;
    stall_left   = 0;
    served       = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (served != hold_off_requests) begin
        served     = hold_off_requests;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Compares each returned item with the oldest expectation; also the watchdog.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    window_result_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_window_results.size() == 0) begin
        $error("unexpected result: window_total %0d, alert %0d",
               out_ch.window_total, out_ch.alert);
        error_count++;
      end else begin
        want = expected_window_results.pop_front();
        if (out_ch.window_total !== want.window_total) begin
          $error("window_total: expected %0d, got %0d", want.window_total,
                 out_ch.window_total);
          error_count++;
        end
        if (out_ch.alert !== want.alert) begin
          $error("alert: expected %0d, got %0d", want.alert, out_ch.alert);
          error_count++;
        end
      end
    end
    if ((out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    error_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_requests  = 0;
    span_cfg           = SPAN_RESET;
    threshold_cfg      = THRESHOLD_RESET;
    clear_histogram();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = '0;
    in_ch.position = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    test_bin_accumulation();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_window_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
